### rtl/utu_pkg.sv
// Shared types, constants and helpers of the UTF-8 to UTF-16 transcoder.
package utu_pkg;

  typedef struct packed {
    logic       action;
    logic [7:0] data_byte;
  } in_word_t;

  typedef struct packed {
    logic [15:0] code_unit;
    logic        last;
  } out_word_t;

  typedef struct packed {
    logic        pre_repl;
    logic        has_cp;
    logic [20:0] cp;
  } cmd_t;

  localparam logic        ActData      = 1'b0;
  localparam logic        ActEnd       = 1'b1;
  localparam logic [7:0]  ContMask     = 8'hC0;
  localparam logic [7:0]  ContTag      = 8'h80;
  localparam logic [7:0]  LeadLow      = 8'hC2;
  localparam logic [7:0]  LeadHigh     = 8'hF4;
  localparam logic [7:0]  Lead3Start   = 8'hE0;
  localparam logic [7:0]  Lead4Start   = 8'hF0;
  localparam logic [7:0]  LeadPayload  = 8'h7F;
  localparam logic [20:0] MaxPoint     = 21'h10FFFF;
  localparam logic [20:0] SurrLow      = 21'h00D800;
  localparam logic [20:0] SurrHigh     = 21'h00DFFF;
  localparam logic [20:0] SuppStart    = 21'h010000;
  localparam logic [20:0] Replacement  = 21'h00FFFD;
  localparam logic [15:0] HighSurrBase = 16'hD800;
  localparam logic [15:0] LowSurrBase  = 16'hDC00;

  function automatic logic [20:0] min_point(input logic [1:0] len);
    logic [20:0] r;
    unique case (len)
      2'd1:    r = 21'h000080;
      2'd2:    r = 21'h000800;
      2'd3:    r = 21'h010000;
      default: r = 21'h000000;
    endcase
    return r;
  endfunction

endpackage

### rtl/utu_front.sv
// Front end: accepts bytes, tracks the open sequence and issues unit commands.
module utu_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  utu_pkg::in_word_t in_word_i,
  output logic            cmd_valid_o,
  output utu_pkg::cmd_t   cmd_o
);

  logic [1:0]  pending_q, pending_d;
  logic [1:0]  len_q, len_d;
  logic [20:0] acc_q, acc_d;

  logic [7:0]  b;
  logic        is_cont;
  logic        is_ascii;
  logic        is_lead;
  logic [1:0]  need;
  logic [20:0] acc_next;
  logic        cp_bad;

  always_comb begin
    b        = in_word_i.data_byte;
    is_cont  = (b & utu_pkg::ContMask) == utu_pkg::ContTag;
    is_ascii = !b[7];
    is_lead  = (b >= utu_pkg::LeadLow) && (b <= utu_pkg::LeadHigh);
    if (b < utu_pkg::Lead3Start) begin
      need = 2'd1;
    end else if (b < utu_pkg::Lead4Start) begin
      need = 2'd2;
    end else begin
      need = 2'd3;
    end
    acc_next = {acc_q[14:0], b[5:0]};
    cp_bad   = (acc_next < utu_pkg::min_point(len_q)) || (acc_next > utu_pkg::MaxPoint) ||
               ((acc_next >= utu_pkg::SurrLow) && (acc_next <= utu_pkg::SurrHigh));
  end

  always_comb begin
    pending_d   = pending_q;
    len_d       = len_q;
    acc_d       = acc_q;
    cmd_valid_o = 1'b0;
    cmd_o       = '0;
    if (in_valid_i) begin
      if (in_word_i.action == utu_pkg::ActEnd) begin
        if (pending_q != 2'd0) begin
          pending_d   = 2'd0;
          cmd_valid_o = 1'b1;
          cmd_o.has_cp = 1'b1;
          cmd_o.cp     = utu_pkg::Replacement;
        end
      end else if ((pending_q != 2'd0) && is_cont) begin
        acc_d     = acc_next;
        pending_d = pending_q - 2'd1;
        if (pending_q == 2'd1) begin
          cmd_valid_o  = 1'b1;
          cmd_o.has_cp = 1'b1;
          cmd_o.cp     = cp_bad ? utu_pkg::Replacement : acc_next;
        end
      end else begin
        // A sequence cut short by a fresh byte yields a replacement first.
        cmd_o.pre_repl = pending_q != 2'd0;
        pending_d      = 2'd0;
        if (is_ascii) begin
          cmd_o.has_cp = 1'b1;
          cmd_o.cp     = {13'd0, b};
        end else if (is_lead) begin
          pending_d = need;
          len_d     = need;
          acc_d     = {13'd0, b & (utu_pkg::LeadPayload >> need)};
        end else begin
          cmd_o.has_cp = 1'b1;
          cmd_o.cp     = utu_pkg::Replacement;
        end
        cmd_valid_o = cmd_o.pre_repl || cmd_o.has_cp;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= 2'd0;
      len_q     <= 2'd0;
      acc_q     <= '0;
    end else begin
      pending_q <= pending_d;
      len_q     <= len_d;
      acc_q     <= acc_d;
    end
  end

endmodule

### rtl/utu_fifo.sv
// Command queue between the front end and the unit sequencer.
module utu_fifo #(
  parameter int unsigned Depth = 4
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          wr_i,
  input  utu_pkg::cmd_t wdata_i,
  input  logic          rd_i,
  output utu_pkg::cmd_t rdata_o,
  output logic          full_o,
  output logic          empty_o
);

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CW = $clog2(Depth + 1);
  localparam logic [AW-1:0] LastIdx = AW'(Depth - 1);

  utu_pkg::cmd_t mem_q [Depth];
  logic [AW-1:0] wptr_q, rptr_q;
  logic [CW-1:0] count_q;
  logic          do_wr, do_rd;

  assign full_o  = count_q == CW'(Depth);
  assign empty_o = count_q == '0;
  assign do_wr   = wr_i && !full_o;
  assign do_rd   = rd_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (do_wr) begin
        wptr_q <= (wptr_q == LastIdx) ? '0 : wptr_q + 1'b1;
      end
      if (do_rd) begin
        rptr_q <= (rptr_q == LastIdx) ? '0 : rptr_q + 1'b1;
      end
      count_q <= count_q + CW'(do_wr) - CW'(do_rd);
    end
  end

`ifndef SYNTHESIS
  a_no_write_when_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(wr_i && full_o)) else $error("command written into a full queue");
  a_no_read_when_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(rd_i && empty_o)) else $error("command read from an empty queue");
  a_count_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(Depth)) else $error("queue count out of range");
`endif

endmodule

### rtl/utu_back.sv
// Back end: expands each command into UTF-16 words in an output register.
module utu_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cmd_valid_i,
  input  utu_pkg::cmd_t     cmd_i,
  output logic              cmd_pop_o,
  input  logic              pop_i,
  output logic              out_valid_o,
  output utu_pkg::out_word_t out_word_o
);

  logic [1:0]  idx_q;
  logic        out_valid_q;
  utu_pkg::out_word_t out_q;

  logic        big;
  logic [1:0]  n_cp;
  logic [1:0]  total;
  logic [1:0]  j;
  logic [19:0] v;
  logic        unit_last;
  logic [15:0] unit;
  logic        load;
  logic        fire;

  always_comb begin
    big   = cmd_i.cp >= utu_pkg::SuppStart;
    n_cp  = cmd_i.has_cp ? (big ? 2'd2 : 2'd1) : 2'd0;
    total = {1'b0, cmd_i.pre_repl} + n_cp;
    j     = idx_q - {1'b0, cmd_i.pre_repl};
    v     = 20'(cmd_i.cp - utu_pkg::SuppStart);
    unit_last = idx_q == (total - 2'd1);
    if (cmd_i.pre_repl && (idx_q == 2'd0)) begin
      unit = utu_pkg::Replacement[15:0];
    end else if (big) begin
      unit = (j == 2'd0) ? (utu_pkg::HighSurrBase | {6'd0, v[19:10]})
                         : (utu_pkg::LowSurrBase | {6'd0, v[9:0]});
    end else begin
      unit = cmd_i.cp[15:0];
    end
  end

  assign load        = !out_valid_q || pop_i;
  assign fire        = cmd_valid_i && load;
  assign cmd_pop_o   = fire && unit_last;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        out_valid_q <= cmd_valid_i;
      end
      if (fire) begin
        idx_q <= unit_last ? 2'd0 : idx_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q.code_unit <= unit;
      out_q.last      <= unit_last;
    end
  end

`ifndef SYNTHESIS
  a_idx_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_valid_i |-> (idx_q < total)) else $error("word index beyond command length");
  a_idx_zero_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cmd_valid_i |-> (idx_q == 2'd0)) else $error("word index left over without command");
  a_not_last_kind : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_q.last) |->
      ((out_q.code_unit == utu_pkg::Replacement[15:0]) ||
       ((out_q.code_unit >= utu_pkg::HighSurrBase) && (out_q.code_unit < utu_pkg::LowSurrBase))))
    else $error("non-final word is neither replacement nor high surrogate");
`endif

endmodule

### rtl/utf8_to_utf16_transcoder.sv
// Top level of the UTF-8 to UTF-16 transcoder.
//
// Input side: one word per accepted push carries a UTF-8 byte or an end of
// stream marker; a word is taken at a clock edge with push high and full low.
// Output side: UTF-16 code units leave in order; the oldest one is shown while
// empty is low and is taken at an edge with pop high. The last flag marks the
// final code unit caused by one input word.
// A byte is accepted every cycle while the command queue has room. A command
// written to the queue moves its first code unit into the output register,
// and empty falls once that register holds it. The unit sequencer issues one
// code unit per cycle while the output register is free or popped, so a byte
// yielding a surrogate pair or a replacement plus a new unit occupies it for
// both units; the command queue of QueueDepth entries absorbs those bursts.
// Reset clears the open sequence, the queue and the output register.
// When the receiver stalls, the output register holds its word, the queue
// fills, and full rises to hold off further bytes.
module utf8_to_utf16_transcoder #(
  parameter int unsigned QueueDepth = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  utu_pkg::in_word_t   in_word_i,
  output logic                empty,
  input  logic                pop,
  output utu_pkg::out_word_t  out_word_o
);

  logic          cmd_wr;
  utu_pkg::cmd_t cmd_w;
  utu_pkg::cmd_t cmd_r;
  logic          cmd_empty;
  logic          cmd_pop;
  logic          out_valid;

  utu_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (push && !full),
    .in_word_i   (in_word_i),
    .cmd_valid_o (cmd_wr),
    .cmd_o       (cmd_w)
  );

  utu_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (cmd_wr),
    .wdata_i (cmd_w),
    .rd_i    (cmd_pop),
    .rdata_o (cmd_r),
    .full_o  (full),
    .empty_o (cmd_empty)
  );

  utu_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (!cmd_empty),
    .cmd_i       (cmd_r),
    .cmd_pop_o   (cmd_pop),
    .pop_i       (pop),
    .out_valid_o (out_valid),
    .out_word_o  (out_word_o)
  );

  assign empty = !out_valid;

endmodule
